/* src/fmtd_pkg.sv */
// Package for the message type decoder: character codes, tags, type nibble
// lookups and output packing widths. No dependencies.
`default_nettype none

package fmtd_pkg;

  localparam int unsigned RING_ENTRIES = 1024;
  localparam int unsigned SLOT_CNT_W   = 16;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned OUT_TDATA_W  = 56;

  localparam logic [7:0]  SEP_RESET   = 8'd59;
  localparam logic [7:0]  CH_EQUALS   = 8'h3D;
  localparam logic [7:0]  CH_ZERO     = 8'h30;
  localparam logic [31:0] TAG_MSGTYPE = 32'd35;
  localparam logic [31:0] TAG_SUBTYPE = 32'd150;

  localparam logic [SLOT_CNT_W-1:0] SLOT_LAST = SLOT_CNT_W'(RING_ENTRIES - 1);

  function automatic logic [7:0] apply_main(input logic [7:0] t, input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h38:   r = t | 8'h80;
      8'h39:   r = t | 8'h90;
      8'h44:   r = t | 8'hD0;
      8'h47:   r = t | 8'hE0;
      8'h46:   r = t | 8'hF0;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] apply_sub(input logic [7:0] t, input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h31 && c <= 8'h39) begin
      r = t | (c - CH_ZERO);
    end else if (c >= 8'h41 && c <= 8'h45) begin
      r = t | (c - 8'h37);
    end else begin
      r = 8'h00;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/fix_message_type_decoder.sv */
// Usage: one message character per request on the in_ stream, in_tlast on
// the final character. Each message yields one result request on out_:
// event_id (wrapping message count), ring_slot, msg_type and bad_value.
// cfg_wr_en / cfg_wr_data set the field separator (reset ';'), written idle.
// Flow: an accepted character is held in the input stage register and is parsed
// from it into the state registers; a last character loads the result register.
// Throughput is one character per cycle while no last character waits; the parse
// state update (tag fold as shift-and-add, type lookup) is the only logic between
// the input stage register and the state and result registers.
// Stalls: a waiting result holds; the input stage keeps taking characters
// that end no message. A last character waits in the input stage until the
// result register frees, and in_tready stays low while it waits.
// Reset (rst_n low, synchronous) empties both stages, zeroes the message
// counter, returns the parser to field start and the separator to ';'.
// Depends on fmtd_pkg.
`default_nettype none

module fix_message_type_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] ch
  input  wire logic                               in_tlast,   // last
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [31:0] event_id, [41:32] ring_slot, [49:42] msg_type, [50] bad_value
  output logic [fmtd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [7:0]                         cfg_wr_data
);
  import fmtd_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_TAG, PH_VALUE, PH_CHECK, PH_SKIP
  } phase_t;

  logic [7:0]            sep_r;
  logic                  stg_valid_r;
  logic [7:0]            stg_ch_r;
  logic                  stg_last_r;

  phase_t                phase_r, phase_nxt;
  logic [31:0]           tag_r, tag_nxt;
  logic [7:0]            type_r, type_nxt;
  logic                  bad_r, bad_nxt;
  logic                  sub_r, sub_nxt;
  logic [31:0]           cnt_r, cnt_nxt;
  logic [SLOT_CNT_W-1:0] slot_r, slot_nxt;

  logic                  out_valid_r;
  logic [31:0]           out_event_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [7:0]            out_type_r;
  logic                  out_bad_r;

  logic                  out_free;
  logic                  stg_adv;
  logic                  out_load;
  logic [31:0]           digit;

  assign out_free  = !out_valid_r || out_tready;
  assign stg_adv   = stg_valid_r && (!stg_last_r || out_free);
  assign out_load  = stg_adv && stg_last_r;
  assign in_tready = !stg_valid_r || stg_adv;

  assign digit   = {24'd0, stg_ch_r} - {24'd0, CH_ZERO};
  assign cnt_nxt = cnt_r + 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    type_nxt  = type_r;
    bad_nxt   = bad_r;
    sub_nxt   = sub_r;
    unique case (phase_r)
      PH_START: begin
        tag_nxt   = digit;
        phase_nxt = PH_TAG;
      end
      PH_TAG: begin
        if (stg_ch_r == CH_EQUALS) begin
          if (tag_r == TAG_MSGTYPE) begin
            sub_nxt   = 1'b0;
            phase_nxt = PH_VALUE;
          end else if (tag_r == TAG_SUBTYPE) begin
            sub_nxt   = 1'b1;
            phase_nxt = PH_VALUE;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else begin
          tag_nxt = (tag_r << 3) + (tag_r << 1) + digit;
        end
      end
      PH_VALUE: begin
        type_nxt  = sub_r ? apply_sub(type_r, stg_ch_r) : apply_main(type_r, stg_ch_r);
        phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (stg_ch_r == sep_r) begin
          phase_nxt = PH_START;
        end else begin
          bad_nxt   = 1'b1;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (stg_ch_r == sep_r) begin
          phase_nxt = PH_START;
        end
      end
      default: phase_nxt = PH_START;
    endcase
  end

  // slot follows counter modulo ring size, also across counter wrap
  always_comb begin
    if (cnt_nxt == 32'd0 || slot_r == SLOT_LAST) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + SLOT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SEP_RESET;
      stg_valid_r <= 1'b0;
      stg_ch_r    <= 8'd0;
      stg_last_r  <= 1'b0;
      phase_r     <= PH_START;
      tag_r       <= 32'd0;
      type_r      <= 8'd0;
      bad_r       <= 1'b0;
      sub_r       <= 1'b0;
      cnt_r       <= 32'd0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      if (in_tready) begin
        stg_valid_r <= in_tvalid;
        stg_ch_r    <= in_tdata;
        stg_last_r  <= in_tlast;
      end
      if (stg_adv) begin
        if (stg_last_r) begin
          phase_r <= PH_START;
          tag_r   <= 32'd0;
          type_r  <= 8'd0;
          bad_r   <= 1'b0;
          sub_r   <= 1'b0;
          cnt_r   <= cnt_nxt;
          slot_r  <= slot_nxt;
        end else begin
          phase_r <= phase_nxt;
          tag_r   <= tag_nxt;
          type_r  <= type_nxt;
          bad_r   <= bad_nxt;
          sub_r   <= sub_nxt;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_event_r <= cnt_nxt;
      out_slot_r  <= SLOT_W'(slot_nxt);
      out_type_r  <= type_nxt;
      out_bad_r   <= bad_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_bad_r, out_type_r, out_slot_r, out_event_r};

`ifndef SYNTHESIS
  a_load_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (stg_valid_r && stg_last_r && out_free))
    else $error("result loaded without a pending last character");

  a_stage_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !stg_adv) |-> !in_tready)
    else $error("input stage accepts while holding an unprocessed character");

  a_event_increments: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_event_r == cnt_r && cnt_r == $past(cnt_r) + 32'd1))
    else $error("event id does not follow message counter");

  a_parser_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (phase_r == PH_START && tag_r == 32'd0 && type_r == 8'd0 && !bad_r))
    else $error("parser not restarted after message end");
`endif

endmodule

`default_nettype wire

/* tb/fix_message_type_decoder_tb.sv */
// Self-checking testbench for fix_message_type_decoder: streams tag=value
// messages under several idling mixes and separator settings and checks every
// result request against a cycle-free predictor. Depends on fmtd_pkg and the DUT.
`timescale 1ns / 100ps

module fix_message_type_decoder_tb;

  import fmtd_pkg::*;

  typedef enum logic [2:0] {FLD_START, FLD_TAG, FLD_VALUE, FLD_CHECK, FLD_SKIP} field_state_t;

  typedef struct {
    logic [31:0]       event_id;
    logic [SLOT_W-1:0] ring_slot;
    logic [7:0]        msg_type;
    logic              bad_value;
  } msg_event_t;

  typedef struct {
    logic [7:0] ch;
    bit         last;
    bit         pinned;
    logic [7:0] msg_type;
    bit         bad_value;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [7:0]             cfg_wr_data = 8'h00;

  // predictor state
  logic [7:0]   separator;
  field_state_t cur_field;
  logic [31:0]  tag_sum;
  logic [7:0]   type_bits;
  logic [31:0]  msg_count;
  bit           long_value;
  bit           sub_value;

  msg_event_t pending_events[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         chars_sent = 0;

  fix_message_type_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit decode_char(input logic [7:0] c, input bit lst, output msg_event_t ev);
    logic [31:0] digit;
    digit = {24'h0, c} - {24'h0, CH_ZERO};
    ev = '{default: '0};
    case (cur_field)
      FLD_START: begin
        tag_sum = digit;
        cur_field = FLD_TAG;
      end
      FLD_TAG: begin
        if (c == CH_EQUALS) begin
          if (tag_sum == TAG_MSGTYPE) begin
            sub_value = 1'b0;
            cur_field = FLD_VALUE;
          end else if (tag_sum == TAG_SUBTYPE) begin
            sub_value = 1'b1;
            cur_field = FLD_VALUE;
          end else begin
            cur_field = FLD_SKIP;
          end
        end else begin
          tag_sum = tag_sum * 32'd10 + digit;
        end
      end
      FLD_VALUE: begin
        if (!sub_value) begin
          case (c)
            "8":     type_bits = type_bits | 8'h80;
            "9":     type_bits = type_bits | 8'h90;
            "D":     type_bits = type_bits | 8'hD0;
            "G":     type_bits = type_bits | 8'hE0;
            "F":     type_bits = type_bits | 8'hF0;
            default: type_bits = 8'h00;
          endcase
        end else if (c >= "1" && c <= "9") begin
          type_bits = type_bits | (c - CH_ZERO);
        end else if (c >= "A" && c <= "E") begin
          type_bits = type_bits | (c - "A" + 8'd10);
        end else begin
          type_bits = 8'h00;
        end
        cur_field = FLD_CHECK;
      end
      FLD_CHECK: begin
        if (c != separator) long_value = 1'b1;
        cur_field = (c == separator) ? FLD_START : FLD_SKIP;
      end
      default: begin
        if (c == separator) cur_field = FLD_START;
      end
    endcase
    if (!lst) return 1'b0;
    msg_count = msg_count + 32'd1;
    ev.event_id  = msg_count;
    ev.ring_slot = SLOT_W'(msg_count % RING_ENTRIES);
    ev.msg_type  = type_bits;
    ev.bad_value = long_value;
    cur_field  = FLD_START;
    tag_sum    = '0;
    type_bits  = '0;
    long_value = 1'b0;
    sub_value  = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] c, input bit lst, input bit pinned = 1'b0,
                           input logic [7:0] p_type = 8'h00, input bit p_bad = 1'b0);
    msg_event_t ev;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (decode_char(c, lst, ev)) begin
      if (pinned) begin
        ev.msg_type  = p_type;
        ev.bad_value = p_bad;
      end
      pending_events.push_back(ev);
    end
  endtask

  task automatic write_separator(input logic [7:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    separator = value;
  endtask

  task automatic push_tag(input bit msgtype, ref logic [7:0] msg[$]);
    if (msgtype) begin
      msg.push_back("3"); msg.push_back("5");
    end else begin
      msg.push_back("1"); msg.push_back("5"); msg.push_back("0");
    end
    msg.push_back(CH_EQUALS);
  endtask

  // well-formed fields with random content, plus noise, long values and truncation
  task automatic send_message();
    logic [7:0] msg[$];
    logic [7:0] main_vals[5] = '{"8", "9", "D", "G", "F"};
    int         nfields;
    int         kind;
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        push_tag(1'b1, msg);
        msg.push_back(($urandom_range(3) != 0) ? main_vals[$urandom_range(4)]
                                                : 8'($urandom_range(255)));
      end else if (kind <= 5) begin
        push_tag(1'b0, msg);
        if ($urandom_range(3) == 0) msg.push_back(8'($urandom_range(255)));
        else if ($urandom_range(1) == 0) msg.push_back(8'($urandom_range("0", "9")));
        else msg.push_back(8'($urandom_range("A", "E")));
      end else if (kind <= 7) begin
        repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range("0", "9")));
        msg.push_back(CH_EQUALS);
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(255)));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
      end else begin
        push_tag($urandom_range(1), msg);
        msg.push_back(main_vals[$urandom_range(4)]);
        repeat ($urandom_range(1, 2)) msg.push_back(8'($urandom_range(255)));
      end
      if (f != nfields - 1 || $urandom_range(1)) msg.push_back(separator);
    end
    if ($urandom_range(9) == 0) msg = msg[0:$urandom_range(msg.size() - 1)];
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
  endtask

  // receiver stalls and result check
  always @(posedge clk) begin
    msg_event_t exp_ev;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result request, actual %h", $time, out_tdata);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_tdata[31:0] !== exp_ev.event_id) begin
          $display("%0t: event_id expected %h actual %h", $time, exp_ev.event_id,
                   out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[41:32] !== exp_ev.ring_slot) begin
          $display("%0t: ring_slot expected %h actual %h", $time, exp_ev.ring_slot,
                   out_tdata[41:32]);
          errors++;
        end
        if (out_tdata[49:42] !== exp_ev.msg_type) begin
          $display("%0t: msg_type expected %h actual %h", $time, exp_ev.msg_type,
                   out_tdata[49:42]);
          errors++;
        end
        if (out_tdata[50] !== exp_ev.bad_value) begin
          $display("%0t: bad_value expected %b actual %b", $time, exp_ev.bad_value,
                   out_tdata[50]);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed[] = '{
      '{"3", 0, 0, 8'h00, 0}, '{"5", 0, 0, 8'h00, 0}, '{"=", 0, 0, 8'h00, 0},
      '{"8", 0, 0, 8'h00, 0}, '{";", 1, 1, 8'h80, 0},
      '{"3", 0, 0, 8'h00, 0}, '{"5", 0, 0, 8'h00, 0}, '{"=", 0, 0, 8'h00, 0},
      '{"D", 0, 0, 8'h00, 0}, '{";", 0, 0, 8'h00, 0}, '{"1", 0, 0, 8'h00, 0},
      '{"5", 0, 0, 8'h00, 0}, '{"0", 0, 0, 8'h00, 0}, '{"=", 0, 0, 8'h00, 0},
      '{"E", 1, 0, 8'h00, 0},
      // long value
      '{"3", 0, 0, 8'h00, 0}, '{"5", 0, 0, 8'h00, 0}, '{"=", 0, 0, 8'h00, 0},
      '{"G", 0, 0, 8'h00, 0}, '{"X", 1, 1, 8'hE0, 1},
      '{8'hFF, 1, 1, 8'h00, 0}, '{8'h00, 1, 1, 8'h00, 0},
      // separator taken as the value
      '{"3", 0, 0, 8'h00, 0}, '{"5", 0, 0, 8'h00, 0}, '{"=", 0, 0, 8'h00, 0},
      '{";", 1, 1, 8'h00, 0}
    };
    logic [7:0] seps[6] = '{SEP_RESET, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h3D};
    separator  = SEP_RESET;
    cur_field  = FLD_START;
    tag_sum    = '0;
    type_bits  = '0;
    msg_count  = '0;
    long_value = 1'b0;
    sub_value  = 1'b0;
    seps[4] = 8'($urandom_range(255));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_char(directed[i].ch, directed[i].last, directed[i].pinned,
                directed[i].msg_type, directed[i].bad_value);

    for (int p = 0; p < 6; p++) begin
      write_separator(seps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      chars_sent = 0;
      while (chars_sent < 200) send_message();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* fix_message_type_decoder.f */
src/fmtd_pkg.sv
src/fix_message_type_decoder.sv
tb/fix_message_type_decoder_tb.sv
